### design/qphs_pkg.sv
// shared constants and types for the quadratic probing hash set
`timescale 1ns / 1ps

package qphs_pkg;

    localparam int KEY_W        = 31;
    localparam int SIZE_W       = 8;
    localparam int SLOT_W       = 7;
    localparam int STATUS_W     = 2;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 3;
    localparam int SLOT_LIMIT   = 128;
    localparam int DEPTH_DEFAULT = 128;
    localparam int CNT_W        = $clog2(KEY_W);

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(128);

    // register index taken from paddr[2]
    localparam logic CFG_TABLE_SIZE = 1'b0;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

    localparam logic KIND_INSERT = 1'b0;

    typedef struct packed {
        logic clear;
        logic wr_en;
    } t_store_ctl;

endpackage

### design/qphs_mod.sv
// serial remainder unit: key mod m, one key bit per cycle
`timescale 1ns / 1ps

module qphs_mod
    import qphs_pkg::*;
#(
    parameter int IDX_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key,
    input  logic [IDX_W:0]   i_m,
    output logic             o_done,
    output logic [IDX_W-1:0] o_rem
);

    localparam int M_W = IDX_W + 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0] r_key;
    logic [IDX_W-1:0] r_rem;
    logic [M_W-1:0]   trial;
    logic [IDX_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_key[KEY_W-1]};
        if (trial >= i_m) begin
            n_rem = IDX_W'(trial - i_m);
        end else begin
            n_rem = trial[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(KEY_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
            r_rem <= '0;
        end else if (r_busy) begin
            r_key <= {r_key[KEY_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### design/qphs_store.sv
// slot memory with registered read and flip-flop occupancy bits
`timescale 1ns / 1ps

module qphs_store
    import qphs_pkg::*;
#(
    parameter int SLOT_CAP = 128,
    parameter int IDX_W    = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_ctl       i_ctl,
    input  logic [IDX_W-1:0] i_rd_addr,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [KEY_W-1:0] i_wr_key,
    output logic [KEY_W-1:0] o_rd_key,
    output logic             o_rd_valid
);

    logic [KEY_W-1:0]    r_mem [SLOT_CAP];
    logic [SLOT_CAP-1:0] r_valid;
    logic [KEY_W-1:0]    r_rd_key;
    logic                r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_key;
        end
        r_rd_key <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_key   = r_rd_key;
    assign o_rd_valid = r_rd_valid;

endmodule

### design/quadratic_probe_hash_set.sv
// top level of the quadratic probing hash set: control, probe sequencer, config port
//
// Usage:
//   An operation (i_kind: 0 insert, 1 search; i_key) is taken at a rising edge
//   where start is high and busy is low. busy stays high until the result beat.
//   The result (o_status, o_slot) is on the ports for one cycle, marked by
//   o_done; the receiver cannot stall it and must take it in that cycle.
//   Sequence: the key mod m remainder is formed first, one key bit per cycle,
//   then one slot memory read per probe cycle, with each read checked in the
//   cycle after it, for at most m probes.
//   The single memory read port sets the probe rate of one probe per cycle.
//   One operation is in flight at a time; start may be taken in the cycle the
//   result beat is shown.
//   Config: table_size at byte address 0 of the APB-style port; any write to
//   it empties the table at once through the occupancy bits. pready is always
//   high. Reset empties the table and sets table_size to 128.
`timescale 1ns / 1ps

module quadratic_probe_hash_set
    import qphs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_kind,
    input  logic [KEY_W-1:0]    i_key,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int SLOT_CAP = (TABLE_DEPTH < SLOT_LIMIT) ? TABLE_DEPTH : SLOT_LIMIT;
    localparam int IDX_W    = $clog2(SLOT_CAP);
    localparam int M_W      = IDX_W + 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DIV   = 3'b010,
        S_PROBE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic                r_kind, n_kind;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [M_W-1:0]      r_m, n_m;
    logic [IDX_W-1:0]    r_s, n_s;
    logic [M_W-1:0]      r_d, n_d;
    logic [M_W-1:0]      r_i, n_i;
    logic                r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]    r_chk_s, n_chk_s;
    logic                r_chk_last, n_chk_last;
    logic                r_done, n_done;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [SIZE_W-1:0]   r_table_size;

    logic                cfg_we;
    logic                accept;
    logic [M_W-1:0]      eff_m;
    logic                mod_done;
    logic [IDX_W-1:0]    mod_rem;
    logic [KEY_W-1:0]    rd_key;
    logic                rd_valid;
    t_store_ctl          store_ctl;
    logic [M_W-1:0]      s_sum;
    logic [M_W-1:0]      d_t1;
    logic [M_W-1:0]      d_t2;
    logic [M_W-1:0]      d_t3;
    logic                fin;
    logic [STATUS_W-1:0] fin_status;
    logic [SLOT_W-1:0]   fin_slot;
    logic                fin_wr;

    assign cfg_we = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_TABLE_SIZE) ? DATA_W'(r_table_size) : '0;
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        if (r_table_size == '0) begin
            eff_m = M_W'(1);
        end else if (r_table_size > SIZE_W'(SLOT_CAP)) begin
            eff_m = M_W'(SLOT_CAP);
        end else begin
            eff_m = M_W'(r_table_size);
        end
    end

    qphs_mod #(
        .IDX_W(IDX_W)
    ) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(accept),
        .i_key  (i_key),
        .i_m    (r_m),
        .o_done (mod_done),
        .o_rem  (mod_rem)
    );

    qphs_store #(
        .SLOT_CAP(SLOT_CAP),
        .IDX_W   (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (store_ctl),
        .i_rd_addr (r_s),
        .i_wr_addr (r_chk_s),
        .i_wr_key  (r_key),
        .o_rd_key  (rd_key),
        .o_rd_valid(rd_valid)
    );

    // next probe slot and next odd step, both kept below m
    always_comb begin
        s_sum = M_W'(r_s) + r_d;
        if (s_sum >= r_m) begin
            s_sum = s_sum - r_m;
        end
        d_t1 = r_d + M_W'(2);
        d_t2 = (d_t1 >= r_m) ? d_t1 - r_m : d_t1;
        d_t3 = (d_t2 >= r_m) ? d_t2 - r_m : d_t2;
    end

    // check of the slot read in the previous cycle
    always_comb begin
        fin        = 1'b0;
        fin_wr     = 1'b0;
        fin_status = ST_MISSING;
        fin_slot   = '0;
        if (r_chk_vld) begin
            if (r_kind == KIND_INSERT) begin
                if (!rd_valid) begin
                    fin        = 1'b1;
                    fin_wr     = 1'b1;
                    fin_status = ST_INSERTED;
                    fin_slot   = SLOT_W'(r_chk_s);
                end else if (r_chk_last) begin
                    fin        = 1'b1;
                    fin_status = ST_FULL;
                end
            end else begin
                if (!rd_valid) begin
                    fin        = 1'b1;
                    fin_status = ST_MISSING;
                end else if (rd_key == r_key) begin
                    fin        = 1'b1;
                    fin_status = ST_FOUND;
                    fin_slot   = SLOT_W'(r_chk_s);
                end else if (r_chk_last) begin
                    fin        = 1'b1;
                    fin_status = ST_MISSING;
                end
            end
        end
    end

    always_comb begin
        n_state         = r_state;
        n_kind          = r_kind;
        n_key           = r_key;
        n_m             = r_m;
        n_s             = r_s;
        n_d             = r_d;
        n_i             = r_i;
        n_chk_vld       = r_chk_vld;
        n_chk_s         = r_chk_s;
        n_chk_last      = r_chk_last;
        n_done          = 1'b0;
        n_status        = r_status;
        n_slot          = r_slot;
        store_ctl.clear = cfg_we && (paddr[2] == CFG_TABLE_SIZE);
        store_ctl.wr_en = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_chk_vld = 1'b0;
                if (start) begin
                    n_state = S_DIV;
                    n_kind  = i_kind;
                    n_key   = i_key;
                    n_m     = eff_m;
                end
            end
            S_DIV: begin
                if (mod_done) begin
                    n_state   = S_PROBE;
                    n_s       = mod_rem;
                    n_d       = (r_m == M_W'(1)) ? '0 : M_W'(1);
                    n_i       = '0;
                    n_chk_vld = 1'b0;
                end
            end
            S_PROBE: begin
                if (fin) begin
                    n_state         = S_IDLE;
                    n_done          = 1'b1;
                    n_status        = fin_status;
                    n_slot          = fin_slot;
                    n_chk_vld       = 1'b0;
                    store_ctl.wr_en = fin_wr;
                end else if (r_i < r_m) begin
                    n_chk_vld  = 1'b1;
                    n_chk_s    = r_s;
                    n_chk_last = (r_i == r_m - M_W'(1));
                    n_s        = s_sum[IDX_W-1:0];
                    n_d        = d_t3;
                    n_i        = r_i + M_W'(1);
                end else begin
                    n_chk_vld = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_chk_vld    <= 1'b0;
            r_done       <= 1'b0;
            r_table_size <= TABLE_SIZE_RST;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= n_chk_vld;
            r_done    <= n_done;
            if (cfg_we && (paddr[2] == CFG_TABLE_SIZE)) begin
                r_table_size <= pwdata[SIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_key      <= n_key;
        r_m        <= n_m;
        r_s        <= n_s;
        r_d        <= n_d;
        r_i        <= n_i;
        r_chk_s    <= n_chk_s;
        r_chk_last <= n_chk_last;
        r_status   <= n_status;
        r_slot     <= n_slot;
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_slot   = r_slot;

endmodule

### dv/qphs_checker.sv
// checker for the quadratic probing hash set: predicts every operation and compares result beats
`timescale 1ns / 1ps

module qphs_checker
    import qphs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic                i_kind,
    input  logic [KEY_W-1:0]    i_key,
    input  logic                i_done,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [ADDR_W-1:0]   i_paddr,
    input  logic [DATA_W-1:0]   i_pwdata,
    input  logic [DATA_W-1:0]   i_prdata,
    output int                  o_err_count,
    output int                  o_pending
);

    localparam int REG_SEL_BIT = 2;
    localparam int SLOT_CAP    = (TABLE_DEPTH < SLOT_LIMIT) ? TABLE_DEPTH : SLOT_LIMIT;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } t_outcome;

    logic [KEY_W-1:0]  key_mem [SLOT_LIMIT];
    logic              slot_used [SLOT_LIMIT];
    logic [SIZE_W-1:0] size_reg;
    t_outcome          outcomes_due [$];

    initial begin
        o_err_count = 0;
        o_pending   = 0;
    end

    task automatic empty_table();
        for (int s = 0; s < SLOT_LIMIT; s++) begin
            slot_used[s] = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        int unsigned m;
        int unsigned home;
        int unsigned probe;
        logic        stop;
        t_outcome    want;
        int          errs;

        errs = o_err_count;
        if (!i_rst_n) begin
            empty_table();
            size_reg = TABLE_SIZE_RST;
            outcomes_due.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr[REG_SEL_BIT] == CFG_TABLE_SIZE) begin
                if (i_pwrite) begin
                    size_reg = i_pwdata[SIZE_W-1:0];
                    empty_table();
                end else if (i_prdata !== DATA_W'(size_reg)) begin
                    $display("%0t: table_size readback mismatch, expected %0d actual %0d",
                             $time, size_reg, i_prdata);
                    errs++;
                end
            end

            // result beat belongs to the oldest operation still open
            if (i_done) begin
                if (outcomes_due.size() == 0) begin
                    $display("%0t: result beat with nothing open, actual status %0d slot %0d",
                             $time, i_status, i_slot);
                    errs++;
                end else begin
                    want = outcomes_due.pop_front();
                    if (i_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, i_status);
                        errs++;
                    end
                    if (i_slot !== want.slot) begin
                        $display("%0t: slot mismatch, expected %0d actual %0d",
                                 $time, want.slot, i_slot);
                        errs++;
                    end
                end
            end

            if (i_start && !i_busy) begin
                m = (size_reg == '0) ? 1 : ((size_reg > SLOT_CAP) ? SLOT_CAP : size_reg);
                home = i_key % m;
                stop = 1'b0;
                if (i_kind == KIND_INSERT) begin
                    want = {ST_FULL, SLOT_W'(0)};
                    for (int unsigned i = 0; i < m && !stop; i++) begin
                        probe = (home + i * i) % m;
                        if (!slot_used[probe]) begin
                            slot_used[probe] = 1'b1;
                            key_mem[probe]   = i_key;
                            want = {ST_INSERTED, SLOT_W'(probe)};
                            stop = 1'b1;
                        end
                    end
                end else begin
                    want = {ST_MISSING, SLOT_W'(0)};
                    for (int unsigned i = 0; i < m && !stop; i++) begin
                        probe = (home + i * i) % m;
                        if (!slot_used[probe]) begin
                            stop = 1'b1;
                        end else if (key_mem[probe] == i_key) begin
                            want = {ST_FOUND, SLOT_W'(probe)};
                            stop = 1'b1;
                        end
                    end
                end
                outcomes_due.push_back(want);
            end
        end
        o_err_count <= errs;
        o_pending   <= outcomes_due.size();
    end

endmodule

### dv/tb_quadratic_probe_hash_set.sv
// testbench top for the quadratic probing hash set: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_quadratic_probe_hash_set;
    import qphs_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_OPS     = 730;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 200;
    localparam int POOL_DEPTH     = 64;

    localparam logic [ADDR_W-1:0] SIZE_ADDR  = {CFG_TABLE_SIZE, 2'b00};
    localparam logic [ADDR_W-1:0] SPARE_ADDR = {~CFG_TABLE_SIZE, 2'b00};
    localparam logic              KIND_SEARCH = ~KIND_INSERT;
    localparam logic [KEY_W-1:0]  KEY_MAX     = '1;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                i_kind  = KIND_INSERT;
    logic [KEY_W-1:0]    i_key   = '0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic                busy;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int err_count;
    int pending;
    int idle_cycles = 0;
    int ops_sent    = 0;
    int cfg_beats   = 0;
    int sizes_used  = 0;
    int n_inserted  = 0;
    int n_full      = 0;
    int n_found     = 0;
    int n_missing   = 0;
    int cur_m       = SLOT_LIMIT;

    logic [KEY_W-1:0] key_pool [$];

    quadratic_probe_hash_set u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_kind   (i_kind),
        .i_key    (i_key),
        .o_done   (o_done),
        .o_status (o_status),
        .o_slot   (o_slot),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    qphs_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_kind      (i_kind),
        .i_key       (i_key),
        .i_done      (o_done),
        .i_status    (o_status),
        .i_slot      (o_slot),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            case (o_status)
                ST_INSERTED: n_inserted <= n_inserted + 1;
                ST_FULL:     n_full     <= n_full + 1;
                ST_FOUND:    n_found    <= n_found + 1;
                default:     n_missing  <= n_missing + 1;
            endcase
        end
    end

    task automatic cfg_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_beats++;
    endtask

    // upper data bits are random, only the low byte is kept
    task automatic set_size(input logic [SIZE_W-1:0] sz);
        logic [DATA_W-1:0] junk;
        junk = $urandom();
        cfg_access(1'b1, SIZE_ADDR, {junk[DATA_W-1:SIZE_W], sz});
        cur_m = (sz == '0) ? 1 : ((sz > SLOT_LIMIT) ? SLOT_LIMIT : sz);
        sizes_used++;
    endtask

    task automatic issue(input logic kind, input logic [KEY_W-1:0] key);
        start  <= 1'b1;
        i_kind <= kind;
        i_key  <= key;
        do @(posedge i_clk); while (busy);
        ops_sent++;
        if (kind == KIND_INSERT) begin
            key_pool.push_back(key);
            if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
        end
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom());
        case ($urandom_range(0, 9))
            0, 1: k = KEY_W'($urandom_range(0, 300));
            2:    k = KEY_MAX - KEY_W'($urandom_range(0, 300));
            3, 4, 5: begin
                // same home slot as a key already in the pool
                if (key_pool.size() != 0)
                    k = key_pool[$urandom_range(0, key_pool.size() - 1)]
                        + KEY_W'(cur_m * $urandom_range(1, 5));
            end
            default: ;
        endcase
        return k;
    endfunction

    initial begin
        int               random_ops;
        int               burst_left;
        int               phase_len;
        logic [SIZE_W-1:0] sz;
        logic [KEY_W-1:0] k;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default size 128: empty search, extreme keys, duplicate, collision miss
        issue(KIND_SEARCH, 31'd5);
        issue(KIND_INSERT, '0);
        issue(KIND_INSERT, KEY_MAX);
        issue(KIND_INSERT, '0);
        issue(KIND_SEARCH, '0);
        issue(KIND_SEARCH, KEY_MAX);
        issue(KIND_SEARCH, 31'd128);
        drain();
        cfg_access(1'b0, SIZE_ADDR, '0);
        cfg_access(1'b1, SPARE_ADDR, $urandom());
        cfg_access(1'b0, SIZE_ADDR, '0);
        issue(KIND_SEARCH, KEY_MAX);
        drain();

        // size zero acts as one slot
        set_size('0);
        issue(KIND_INSERT, 31'd5);
        issue(KIND_INSERT, 31'd9);
        issue(KIND_SEARCH, 31'd9);
        issue(KIND_SEARCH, 31'd5);
        drain();

        // oversize saturates, write clears
        set_size('1);
        cfg_access(1'b0, SIZE_ADDR, '0);
        issue(KIND_SEARCH, 31'd5);
        drain();

        // size 7: probe path covers only part of the table
        set_size(SIZE_W'(7));
        issue(KIND_INSERT, 31'd3);
        issue(KIND_INSERT, 31'd10);
        issue(KIND_INSERT, 31'd17);
        issue(KIND_INSERT, 31'd24);
        issue(KIND_INSERT, 31'd31);
        issue(KIND_SEARCH, 31'd31);
        issue(KIND_SEARCH, 31'd24);
        drain();

        set_size(SIZE_W'(1));
        set_size(SIZE_W'(SLOT_LIMIT));
        cfg_access(1'b0, SIZE_ADDR, '0);
        issue(KIND_INSERT, 31'h5555_5555);
        issue(KIND_SEARCH, 31'h5555_5555);
        issue(KIND_INSERT, KEY_W'($urandom()));

        random_ops = 0;
        burst_left = $urandom_range(1, 25);
        while (random_ops < RANDOM_OPS) begin
            case ($urandom_range(0, 9))
                0:       sz = SIZE_W'($urandom_range(0, 1));
                1, 2, 3: sz = SIZE_W'($urandom_range(2, 8));
                4, 5:    sz = SIZE_W'($urandom_range(9, 40));
                6:       sz = SIZE_W'($urandom_range(41, 127));
                7:       sz = SIZE_W'(SLOT_LIMIT);
                8:       sz = SIZE_W'($urandom_range(129, 255));
                default: sz = SIZE_W'($urandom_range(0, 255));
            endcase
            drain();
            set_size(sz);
            if ($urandom_range(0, 3) == 0) cfg_access(1'b0, SIZE_ADDR, '0);
            if ($urandom_range(0, 5) == 0) cfg_access(1'b1, SPARE_ADDR, $urandom());
            phase_len = $urandom_range(30, 80);
            repeat (phase_len) begin
                if ($urandom_range(0, 1) == 0) begin
                    if (key_pool.size() != 0 && $urandom_range(0, 6) == 0)
                        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                    else
                        k = pick_key();
                    issue(KIND_INSERT, k);
                end else begin
                    if (key_pool.size() != 0 && $urandom_range(0, 19) < 11)
                        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                    else
                        k = pick_key();
                    issue(KIND_SEARCH, k);
                end
                random_ops++;
                burst_left--;
                if (burst_left == 0) begin
                    pause($urandom_range(1, 60));
                    burst_left = $urandom_range(1, 25);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d operations: %0d inserted, %0d full, %0d found, %0d not found",
                 ops_sent, n_inserted, n_full, n_found, n_missing);
        $display("%0d register beats, %0d table size writes", cfg_beats, sizes_used);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
